[hdl/assert_macros.svh]
// Assertion macros shared by the receive chain and the top level.
// Needs nothing else; include by bare file name inside a module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define URFRB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that trig implies prop in the cycle after trig.
`define URFRB_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
    else $error(msg);

`endif

[hdl/urfrb_pkg.sv]
// Shared types and constants of the UART receive-FIFO register block.
// No dependencies; imported by the interfaces and all modules.
package urfrb_pkg;

  localparam int unsigned RX_FIFO_DEPTH_DEF = 8;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned OP_W              = 2;
  localparam int unsigned IDX_W             = 3;
  localparam int unsigned IRQ_RXWM_BIT      = 1;

  localparam logic [DATA_W-1:0] RX_EMPTY_CODE = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LINE  = 2'd2
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TXDATA = 3'd0,
    REG_RXDATA = 3'd1,
    REG_TXCTRL = 3'd2,
    REG_RXCTRL = 3'd3,
    REG_IE     = 3'd4,
    REG_IP     = 3'd5,
    REG_DIV    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic push;
    logic pop;
  } rx_ctrl_t;

  typedef struct packed {
    logic empty;
    logic one;
    logic almost_full;
    logic full;
  } rx_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              irq_line;
    logic              rx_ready;
    logic              rx_dropped;
    logic              bad_access;
  } res_t;

endpackage

[hdl/urfrb_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on urfrb_pkg.
interface urfrb_in_if;
  import urfrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  reg_index;
  logic [DATA_W-1:0] write_data;
  logic [BYTE_W-1:0] line_byte;

  modport source (output valid, output op, output reg_index, output write_data,
                  output line_byte, input ready);
  modport sink   (input valid, input op, input reg_index, input write_data,
                  input line_byte, output ready);
endinterface

interface urfrb_out_if;
  import urfrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              irq_line;
  logic              rx_ready;
  logic              rx_dropped;
  logic              bad_access;

  modport source (output valid, output read_data, output tx_valid, output tx_byte,
                  output irq_line, output rx_ready, output rx_dropped,
                  output bad_access, input ready);
  modport sink   (input valid, input read_data, input tx_valid, input tx_byte,
                  input irq_line, input rx_ready, input rx_dropped,
                  input bad_access, output ready);
endinterface

[hdl/urfrb_cell.sv]
// One byte cell of the receive chain: loads a line byte or takes its neighbor's.
// Depends on urfrb_pkg.
module urfrb_cell (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      shift,
  input  logic [urfrb_pkg::BYTE_W-1:0] load_byte,
  input  logic [urfrb_pkg::BYTE_W-1:0] next_byte,
  output logic [urfrb_pkg::BYTE_W-1:0] cell_byte
);
  import urfrb_pkg::*;

  logic [BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= load_byte;
    end else if (shift) begin
      byte_r <= next_byte;
    end
  end

  assign cell_byte = byte_r;

endmodule

[hdl/urfrb_rx_chain.sv]
// Receive FIFO as a row of byte cells with the head in cell 0 and a fill count.
// Depends on urfrb_pkg, urfrb_cell and assert_macros.svh.
`include "assert_macros.svh"

module urfrb_rx_chain #(
  parameter int unsigned RX_FIFO_DEPTH = urfrb_pkg::RX_FIFO_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  urfrb_pkg::rx_ctrl_t          ctrl,
  input  logic [urfrb_pkg::BYTE_W-1:0] line_byte,
  output logic [urfrb_pkg::BYTE_W-1:0] head_byte,
  output urfrb_pkg::rx_stat_t          stat
);
  import urfrb_pkg::*;

  localparam int unsigned CW = $clog2(RX_FIFO_DEPTH + 1);

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [BYTE_W-1:0] cell_q [RX_FIFO_DEPTH];

  genvar i;
  generate
    for (i = 0; i < RX_FIFO_DEPTH; i++) begin : g_cell
      logic [BYTE_W-1:0] next_byte;
      if (i == RX_FIFO_DEPTH - 1) begin : g_tail
        assign next_byte = cell_q[i];
      end else begin : g_mid
        assign next_byte = cell_q[i+1];
      end
      urfrb_cell u_cell (
        .clk       (clk),
        .load      (ctrl.push && (count_r == CW'(i))),
        .shift     (ctrl.pop),
        .load_byte (line_byte),
        .next_byte (next_byte),
        .cell_byte (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_byte        = cell_q[0];
  assign stat.empty       = (count_r == '0);
  assign stat.one         = (count_r == CW'(1));
  assign stat.almost_full = (count_r == CW'(RX_FIFO_DEPTH - 1));
  assign stat.full        = (count_r == CW'(RX_FIFO_DEPTH));

  `URFRB_ASSERT(a_count_range, clk, rst_n, count_r <= CW'(RX_FIFO_DEPTH), "fill count overflow")
  `URFRB_ASSERT(a_no_push_full, clk, rst_n, !(ctrl.push && stat.full), "push into full chain")
  `URFRB_ASSERT(a_no_pop_empty, clk, rst_n, !(ctrl.pop && stat.empty), "pop from empty chain")

endmodule

[hdl/uart_rx_fifo_register_block_top.sv]
// Top level of the UART register block: decode, control registers, result register.
// Depends on urfrb_pkg, urfrb_if, urfrb_rx_chain and assert_macros.svh.
//
//  channel   | dir | beat contents
//  ----------+-----+------------------------------------------------------------
//  in_chan   | in  | op, reg_index, write_data, line_byte
//  out_chan  | out | read_data, tx_valid, tx_byte, irq_line, rx_ready,
//            |     | rx_dropped, bad_access
//
// One beat in per cycle if not stalled; one result out per beat, in the next cycle.
// All state (cell row, fill count, control registers) updates at the accept edge.
// The result register frees up in the same cycle it is drained, so in_chan is
// ready whenever out_chan is empty or is being taken; a stalled out_chan holds it.
// Reset (rst_n low, synchronous) empties the FIFO and clears ie, txctrl, rxctrl, div.
`include "assert_macros.svh"

module uart_rx_fifo_register_block_top #(
  parameter int unsigned RX_FIFO_DEPTH = urfrb_pkg::RX_FIFO_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  urfrb_in_if.sink    in_chan,
  urfrb_out_if.source out_chan
);
  import urfrb_pkg::*;

  logic              in_acc;
  rx_ctrl_t          ctrl;
  rx_stat_t          stat;
  logic [BYTE_W-1:0] head_byte;

  logic [DATA_W-1:0] ie_r, ie_nxt;
  logic [DATA_W-1:0] txctrl_r, txctrl_nxt;
  logic [DATA_W-1:0] rxctrl_r, rxctrl_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic              out_valid_r;
  res_t              res_r, res_nxt;
  logic              empty_after;
  logic              full_after;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  urfrb_rx_chain #(
    .RX_FIFO_DEPTH (RX_FIFO_DEPTH)
  ) u_rx_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .line_byte (in_chan.line_byte),
    .head_byte (head_byte),
    .stat      (stat)
  );

  always_comb begin
    ctrl       = '0;
    res_nxt    = '0;
    ie_nxt     = ie_r;
    txctrl_nxt = txctrl_r;
    rxctrl_nxt = rxctrl_r;
    div_nxt    = div_r;
    if (in_acc) begin
      case (op_t'(in_chan.op))
        OP_READ: begin
          unique case (reg_idx_t'(in_chan.reg_index))
            REG_TXDATA: res_nxt.read_data = '0;
            REG_RXDATA: begin
              if (stat.empty) begin
                res_nxt.read_data = RX_EMPTY_CODE;
              end else begin
                res_nxt.read_data = {{(DATA_W-BYTE_W){1'b0}}, head_byte};
                ctrl.pop          = 1'b1;
              end
            end
            REG_TXCTRL: res_nxt.read_data = txctrl_r;
            REG_RXCTRL: res_nxt.read_data = rxctrl_r;
            REG_IE:     res_nxt.read_data = ie_r;
            REG_IP:     res_nxt.read_data[IRQ_RXWM_BIT] = !stat.empty;
            REG_DIV:    res_nxt.read_data = div_r;
            default:    res_nxt.bad_access = 1'b1;
          endcase
        end
        OP_WRITE: begin
          unique case (reg_idx_t'(in_chan.reg_index))
            REG_TXDATA: begin
              res_nxt.tx_valid = 1'b1;
              res_nxt.tx_byte  = in_chan.write_data[BYTE_W-1:0];
            end
            REG_TXCTRL: txctrl_nxt = in_chan.write_data;
            REG_RXCTRL: rxctrl_nxt = in_chan.write_data;
            REG_IE:     ie_nxt     = in_chan.write_data;
            REG_DIV:    div_nxt    = in_chan.write_data;
            default:    res_nxt.bad_access = 1'b1;
          endcase
        end
        OP_LINE: begin
          if (stat.full) begin
            res_nxt.rx_dropped = 1'b1;
          end else begin
            ctrl.push = 1'b1;
          end
        end
        default: res_nxt.read_data = '0;
      endcase
    end
    empty_after = ctrl.pop ? stat.one : (ctrl.push ? 1'b0 : stat.empty);
    full_after  = ctrl.push ? stat.almost_full : (ctrl.pop ? 1'b0 : stat.full);
    res_nxt.irq_line = ie_nxt[IRQ_RXWM_BIT] && !empty_after;
    res_nxt.rx_ready = !full_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ie_r        <= '0;
      txctrl_r    <= '0;
      rxctrl_r    <= '0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ie_r     <= ie_nxt;
      txctrl_r <= txctrl_nxt;
      rxctrl_r <= rxctrl_nxt;
      div_r    <= div_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_data  = res_r.read_data;
  assign out_chan.tx_valid   = res_r.tx_valid;
  assign out_chan.tx_byte    = res_r.tx_byte;
  assign out_chan.irq_line   = res_r.irq_line;
  assign out_chan.rx_ready   = res_r.rx_ready;
  assign out_chan.rx_dropped = res_r.rx_dropped;
  assign out_chan.bad_access = res_r.bad_access;

  `URFRB_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_acc, out_valid_r, "beat lost")
  `URFRB_ASSERT_NEXT(a_full_drops, clk, rst_n,
    in_acc && (in_chan.op == OP_LINE) && stat.full, res_r.rx_dropped && !res_r.rx_ready,
    "line byte into full FIFO not dropped")
  `URFRB_ASSERT(a_irq_needs_enable, clk, rst_n,
    !(out_valid_r && res_r.irq_line && !ie_r[IRQ_RXWM_BIT]), "irq without enable")

endmodule

[verif/urfrb_checker.sv]
// Checker for the UART receive-FIFO register block: predicts each result beat
// from accepted input beats and compares it field by field.
// Depends on urfrb_pkg and the channel interfaces in urfrb_if.
module urfrb_checker (
  input  logic clk,
  input  logic rst_n,
  urfrb_in_if  in_mon,
  urfrb_out_if out_mon,
  output int   mismatches,
  output int   outstanding
);
  import urfrb_pkg::*;

  localparam int unsigned DEPTH = RX_FIFO_DEPTH_DEF;

  logic [BYTE_W-1:0] rx_bytes [DEPTH];
  int unsigned       rx_fill;
  int unsigned       rx_rd;
  logic [DATA_W-1:0] ie_q;
  logic [DATA_W-1:0] txctrl_q;
  logic [DATA_W-1:0] rxctrl_q;
  logic [DATA_W-1:0] div_q;
  res_t              owed_beats [$];

  function automatic res_t predict_access(input logic [OP_W-1:0] op,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] wd,
                                          input logic [BYTE_W-1:0] lb);
    res_t r;
    r = '0;
    case (op)
      OP_READ: begin
        case (idx)
          REG_TXDATA: r.read_data = '0;
          REG_RXDATA: begin
            if (rx_fill != 0) begin
              r.read_data = {{(DATA_W-BYTE_W){1'b0}}, rx_bytes[rx_rd]};
              rx_rd       = (rx_rd + 1) % DEPTH;
              rx_fill--;
            end else begin
              r.read_data = RX_EMPTY_CODE;
            end
          end
          REG_TXCTRL: r.read_data = txctrl_q;
          REG_RXCTRL: r.read_data = rxctrl_q;
          REG_IE:     r.read_data = ie_q;
          REG_IP:     r.read_data = (rx_fill != 0) ? (DATA_W'(1) << IRQ_RXWM_BIT) : '0;
          REG_DIV:    r.read_data = div_q;
          default:    r.bad_access = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (idx)
          REG_TXDATA: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = wd[BYTE_W-1:0];
          end
          REG_TXCTRL: txctrl_q = wd;
          REG_RXCTRL: rxctrl_q = wd;
          REG_IE:     ie_q     = wd;
          REG_DIV:    div_q    = wd;
          default:    r.bad_access = 1'b1;
        endcase
      end
      OP_LINE: begin
        if (rx_fill >= DEPTH) begin
          r.rx_dropped = 1'b1;
        end else begin
          rx_bytes[(rx_rd + rx_fill) % DEPTH] = lb;
          rx_fill++;
        end
      end
      default: ;
    endcase
    r.irq_line = ie_q[IRQ_RXWM_BIT] && (rx_fill != 0);
    r.rx_ready = (rx_fill < DEPTH);
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", fname, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      rx_fill  = 0;
      rx_rd    = 0;
      ie_q     = '0;
      txctrl_q = '0;
      rxctrl_q = '0;
      div_q    = '0;
      owed_beats.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          want = owed_beats.pop_front();
          check_field("read_data", want.read_data, out_mon.read_data);
          check_field("tx_valid", DATA_W'(want.tx_valid), DATA_W'(out_mon.tx_valid));
          check_field("tx_byte", DATA_W'(want.tx_byte), DATA_W'(out_mon.tx_byte));
          check_field("irq_line", DATA_W'(want.irq_line), DATA_W'(out_mon.irq_line));
          check_field("rx_ready", DATA_W'(want.rx_ready), DATA_W'(out_mon.rx_ready));
          check_field("rx_dropped", DATA_W'(want.rx_dropped),
                      DATA_W'(out_mon.rx_dropped));
          check_field("bad_access", DATA_W'(want.bad_access),
                      DATA_W'(out_mon.bad_access));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_beats.push_back(predict_access(in_mon.op, in_mon.reg_index,
                                            in_mon.write_data, in_mon.line_byte));
      end
    end
    outstanding = owed_beats.size();
  end

endmodule

[verif/testbench.sv]
// Top of the UART receive-FIFO register block testbench: clock, reset, beat
// stimulus with random idling and back-pressure, and the final verdict.
// Depends on urfrb_pkg, urfrb_if, urfrb_checker and the block's top level.
module testbench;
  import urfrb_pkg::*;

  localparam logic [OP_W-1:0]  OP_NONE      = 2'd3;
  localparam logic [IDX_W-1:0] REG_UNDEF    = 3'd7;
  localparam int               RANDOM_BEATS = 1525;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  bit   quiet;
  int   stall_req;

  urfrb_in_if  in_chan ();
  urfrb_out_if out_chan ();

  uart_rx_fifo_register_block_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  urfrb_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("uart_rx_fifo_register_block_top regression: fail");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (stall_req > 0) begin
        hold_left = stall_req - 1;
        stall_req = 0;
        out_chan.ready <= 1'b0;
      end else if (quiet) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wd, input logic [BYTE_W-1:0] lb);
    in_chan.valid      <= 1'b1;
    in_chan.op         <= op;
    in_chan.reg_index  <= idx;
    in_chan.write_data <= wd;
    in_chan.line_byte  <= lb;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(99) < 15) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic random_beat(input int line_pct, input int pop_pct);
    int                pick;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wd;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       wd = '0;
      1:       wd = '1;
      default: wd = $urandom;
    endcase
    if (pick < line_pct) begin
      op  = OP_LINE;
      idx = IDX_W'($urandom_range(7));
    end else if (pick < line_pct + pop_pct) begin
      op  = OP_READ;
      idx = REG_RXDATA;
    end else begin
      op  = OP_W'($urandom_range(3));
      idx = IDX_W'($urandom_range(7));
    end
    send_beat(op, idx, wd, BYTE_W'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int line_pct;
    int pop_pct;
    line_pct = 40;
    pop_pct  = 30;
    quiet     = 1'b0;
    stall_req = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.op         <= OP_READ;
    in_chan.reg_index  <= REG_TXDATA;
    in_chan.write_data <= '0;
    in_chan.line_byte  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(OP_READ, REG_TXDATA, '0, '0);
    send_beat(OP_READ, REG_RXDATA, '0, '0);
    send_beat(OP_READ, REG_IP, '0, '0);
    send_beat(OP_READ, REG_UNDEF, '0, '0);
    send_beat(OP_WRITE, REG_IE, '1, '0);
    send_beat(OP_WRITE, REG_TXCTRL, '1, '0);
    send_beat(OP_WRITE, REG_RXCTRL, '0, '0);
    send_beat(OP_WRITE, REG_DIV, '1, '0);
    send_beat(OP_WRITE, REG_TXDATA, '1, '0);
    send_beat(OP_WRITE, REG_TXDATA, '0, '1);
    send_beat(OP_WRITE, REG_RXDATA, '1, '0);
    send_beat(OP_WRITE, REG_IP, '1, '0);
    send_beat(OP_WRITE, REG_UNDEF, '1, '0);
    send_beat(OP_NONE, REG_UNDEF, '1, '1);
    send_beat(OP_LINE, REG_TXDATA, '0, 8'hFF);
    send_beat(OP_LINE, REG_TXDATA, '0, 8'h00);
    for (int k = 0; k < 7; k++) begin
      send_beat(OP_LINE, REG_TXDATA, '0, BYTE_W'($urandom_range(255)));
    end
    send_beat(OP_READ, REG_IP, '0, '0);
    send_beat(OP_READ, REG_RXDATA, '0, '0);
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) begin
        line_pct = $urandom_range(10, 60);
        pop_pct  = $urandom_range(10, 40);
      end
      quiet = (n >= 600 && n < 800);
      if (n == 300 || n == 1100) stall_req = 60;
      if (n == 900) drain();
      random_beat(line_pct, pop_pct);
      idle_gap();
    end
    in_chan.valid <= 1'b0;

    for (int w = 0; w < 5000 && outstanding != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (outstanding == 0 && mismatches == 0) begin
      $display("uart_rx_fifo_register_block_top regression: pass");
    end else begin
      $display("uart_rx_fifo_register_block_top regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/urfrb_pkg.sv
hdl/urfrb_if.sv
hdl/urfrb_cell.sv
hdl/urfrb_rx_chain.sv
hdl/uart_rx_fifo_register_block_top.sv
verif/urfrb_checker.sv
verif/testbench.sv
